>>> hw/rtl/kwm_pkg.sv
`timescale 1ns / 1ps

package kwm_pkg;

    localparam int LANES      = 8;
    localparam int LANE_DEPTH = 16;

    localparam int DATA_W = 32;
    localparam int LANE_W = $clog2(LANES);
    localparam int SCAN_W = LANE_W + 1;
    localparam int IDX_W  = $clog2(LANE_DEPTH);
    localparam int CNT_W  = $clog2(LANE_DEPTH + 1);
    localparam int ADDR_W = $clog2(LANES * LANE_DEPTH);

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_POP    = 1'b1
    } command_t;

    typedef enum logic [1:0]
    {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_POPPED   = 2'd2,
        ST_EMPTY    = 2'd3
    } result_code_t;

    typedef struct packed
    {
        command_t           command;
        logic [2:0]         lane;
        logic signed [31:0] value;
    } req_item_t;

    typedef struct packed
    {
        logic signed [31:0] result_value;
        logic [2:0]         source_lane;
        result_code_t       status;
    } rsp_item_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_CMP,
        S_SCAN,
        S_SCAN_CMP,
        S_POP_RD,
        S_POP_WR,
        S_DONE
    } state_t;

    typedef struct packed
    {
        logic         capture;
        logic         ins_rd;
        logic         wr_shift_up;
        logic         wr_value;
        logic         dec_k;
        logic         inc_count;
        logic         scan_rd;
        logic         scan_update;
        logic         scan_next;
        logic         pop_init;
        logic         pop_rd;
        logic         pop_wr;
        logic         dec_count;
        logic         out_load;
        result_code_t out_code;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic is_pop;
        logic lane_refused;
        logic k_zero;
        logic v_less;
        logic scan_done;
        logic scan_nonempty;
        logic found;
        logic pop_more;
        logic out_free;
    } ctrl_status_t;

endpackage

>>> hw/rtl/kwm_req_if.sv
`timescale 1ns / 1ps

interface kwm_req_if
    import kwm_pkg::*;
();

    logic      valid;
    logic      ready;
    req_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);

endinterface

>>> hw/rtl/kwm_rsp_if.sv
`timescale 1ns / 1ps

interface kwm_rsp_if
    import kwm_pkg::*;
();

    logic      valid;
    logic      ready;
    rsp_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);

endinterface

>>> hw/rtl/k_way_sorted_merge.sv
`timescale 1ns / 1ps
// insert: entries larger than the value are read and shifted up one place, then the value is written
// an insert into a full lane is refused with no memory access
// pop: every lane is scanned, each nonempty head compared, then the winning lane shifts down one place
// empty pop: every lane is scanned and empty is returned; one transaction in work at a time
// the next transaction is taken while the previous result waits at the output
// rst_n asynchronous active low: all lanes empty, no result pending, no clearing pass
module k_way_sorted_merge
    import kwm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    kwm_req_if.sink        req,
    kwm_rsp_if.source      rsp
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic         req_ready;
    logic         rsp_valid;
    rsp_item_t    rsp_item;

    kwm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    kwm_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req.item),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_item  (rsp_item),
        .rsp_ready (rsp.ready)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign rsp.item  = rsp_item;

endmodule

>>> hw/rtl/kwm_dpath.sv
`timescale 1ns / 1ps

module kwm_dpath
    import kwm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  req_item_t    req_item,
    input  ctrl_cmd_t    cmd,
    output ctrl_status_t status,
    output logic         rsp_valid,
    output rsp_item_t    rsp_item,
    input  logic         rsp_ready
);

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [LANE_W-1:0] ln,
                                                   input logic [IDX_W-1:0] ix);
        return ADDR_W'(ln) * ADDR_W'(LANE_DEPTH) + ADDR_W'(ix);
    endfunction

    command_t           command_reg;
    logic [2:0]         lane_reg;
    logic signed [31:0] value_reg;

    logic [CNT_W-1:0]   count_reg [LANES];
    logic [CNT_W-1:0]   k_reg;
    logic [SCAN_W-1:0]  scan_reg;
    logic               found_reg;
    logic [LANE_W-1:0]  best_lane_reg;
    logic signed [31:0] best_value_reg;
    logic signed [31:0] rd_data_reg;
    logic               out_valid_reg;
    rsp_item_t          out_item_reg;

    logic signed [31:0] mem [LANES * LANE_DEPTH];

    logic [LANE_W-1:0]  lane_idx;
    logic [LANE_W-1:0]  scan_lane;
    logic [CNT_W-1:0]   k_dec;
    logic               lane_bad;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic signed [31:0] wr_data;
    rsp_item_t          out_item_next;

    assign lane_idx  = LANE_W'(lane_reg);
    assign scan_lane = scan_reg[LANE_W-1:0];
    assign k_dec     = k_reg - CNT_W'(1);
    assign lane_bad  = int'(lane_reg) >= LANES;

    always_comb
    begin
        status.is_pop        = (command_reg == CMD_POP);
        status.lane_refused  = lane_bad || (count_reg[lane_idx] >= CNT_W'(LANE_DEPTH));
        status.k_zero        = (k_reg == '0);
        status.v_less        = (value_reg < rd_data_reg);
        status.scan_done     = (scan_reg == SCAN_W'(LANES));
        status.scan_nonempty = (count_reg[scan_lane] != '0);
        status.found         = found_reg;
        status.pop_more      = (k_reg < count_reg[best_lane_reg]);
        status.out_free      = !out_valid_reg || rsp_ready;
    end

    // memory port selection
    always_comb
    begin
        rd_en   = cmd.ins_rd || cmd.scan_rd || cmd.pop_rd;
        rd_addr = mem_addr(best_lane_reg, IDX_W'(k_reg));
        if (cmd.ins_rd)
        begin
            rd_addr = mem_addr(lane_idx, IDX_W'(k_dec));
        end
        else if (cmd.scan_rd)
        begin
            rd_addr = mem_addr(scan_lane, '0);
        end

        wr_en   = cmd.wr_shift_up || cmd.wr_value || cmd.pop_wr;
        wr_addr = mem_addr(lane_idx, IDX_W'(k_reg));
        wr_data = rd_data_reg;
        if (cmd.wr_value)
        begin
            wr_data = value_reg;
        end
        else if (cmd.pop_wr)
        begin
            wr_addr = mem_addr(best_lane_reg, IDX_W'(k_dec));
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            command_reg <= req_item.command;
            lane_reg    <= req_item.lane;
            value_reg   <= req_item.value;
        end
        if (cmd.scan_update && (!found_reg || !(best_value_reg < rd_data_reg)))
        begin
            best_lane_reg  <= scan_lane;
            best_value_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            scan_reg  <= '0;
            found_reg <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.capture)
            begin
                k_reg     <= count_reg[LANE_W'(req_item.lane)];
                scan_reg  <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.dec_k)
            begin
                k_reg <= k_dec;
            end
            else if (cmd.pop_init)
            begin
                k_reg <= CNT_W'(1);
            end
            else if (cmd.pop_wr)
            begin
                k_reg <= k_reg + CNT_W'(1);
            end

            if (cmd.scan_next)
            begin
                scan_reg <= scan_reg + SCAN_W'(1);
            end
            if (cmd.scan_update)
            begin
                found_reg <= 1'b1;
            end

            if (cmd.inc_count)
            begin
                count_reg[lane_idx] <= count_reg[lane_idx] + CNT_W'(1);
            end
            else if (cmd.dec_count)
            begin
                count_reg[best_lane_reg] <= count_reg[best_lane_reg] - CNT_W'(1);
            end
        end
    end

    // result register
    always_comb
    begin
        out_item_next.status       = cmd.out_code;
        out_item_next.result_value = '0;
        out_item_next.source_lane  = '0;
        if (cmd.out_code == ST_POPPED)
        begin
            out_item_next.result_value = best_value_reg;
            out_item_next.source_lane  = 3'(best_lane_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_item_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.inc_count |-> count_reg[lane_idx] < CNT_W'(LANE_DEPTH))
        else $error("insert into a full lane");

    a_shift_k: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_shift_up |-> k_reg != '0)
        else $error("shift up with empty position counter");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || rsp_ready))
        else $error("result overwritten before transaction");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_update |-> count_reg[scan_lane] != '0)
        else $error("head compare on an empty lane");
`endif

endmodule

>>> hw/rtl/kwm_ctrl.sv
`timescale 1ns / 1ps

module kwm_ctrl
    import kwm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t       state_reg;
    state_t       state_next;
    result_code_t res_reg;
    result_code_t res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= ST_INSERTED;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        res_next     = res_reg;
        cmd          = '0;
        cmd.out_code = res_reg;
        req_ready    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.is_pop)
                begin
                    state_next = S_SCAN;
                end
                else if (status.lane_refused)
                begin
                    res_next   = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                if (status.k_zero)
                begin
                    cmd.wr_value  = 1'b1;
                    cmd.inc_count = 1'b1;
                    res_next      = ST_INSERTED;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.ins_rd = 1'b1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (status.v_less)
                begin
                    cmd.wr_shift_up = 1'b1;
                    cmd.dec_k       = 1'b1;
                    state_next      = S_INS_RD;
                end
                else
                begin
                    cmd.wr_value  = 1'b1;
                    cmd.inc_count = 1'b1;
                    res_next      = ST_INSERTED;
                    state_next    = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (status.scan_done)
                begin
                    if (status.found)
                    begin
                        cmd.pop_init = 1'b1;
                        state_next   = S_POP_RD;
                    end
                    else
                    begin
                        res_next   = ST_EMPTY;
                        state_next = S_DONE;
                    end
                end
                else if (status.scan_nonempty)
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_CMP;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_SCAN_CMP:
            begin
                cmd.scan_update = 1'b1;
                cmd.scan_next   = 1'b1;
                state_next      = S_SCAN;
            end
            S_POP_RD:
            begin
                if (status.pop_more)
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POP_WR;
                end
                else
                begin
                    cmd.dec_count = 1'b1;
                    res_next      = ST_POPPED;
                    state_next    = S_DONE;
                end
            end
            S_POP_WR:
            begin
                cmd.pop_wr = 1'b1;
                state_next = S_POP_RD;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && status.out_free) |=> state_reg == S_IDLE)
        else $error("result stage did not return to idle");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req_valid) |=> state_reg == S_DISPATCH)
        else $error("accepted transaction not dispatched");

    a_pop_loop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP_WR |=> state_reg == S_POP_RD)
        else $error("pop shift left its loop");
`endif

endmodule

>>> verif/kwm_merge_checker.sv
`timescale 1ns / 1ps

module kwm_merge_checker
    import kwm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    kwm_req_if   req,
    kwm_rsp_if   rsp,
    output int   errors,
    output int   pending,
    output int   inserted,
    output int   refused,
    output int   popped,
    output int   empty_pops
);

    logic signed [DATA_W-1:0] lane_mem [LANES][LANE_DEPTH];
    int unsigned              lane_fill [LANES];
    rsp_item_t                expected_results [$];
    rsp_item_t                want;

    function automatic rsp_item_t predict_merge_result(req_item_t it);
        rsp_item_t                res;
        logic signed [DATA_W-1:0] v;
        int unsigned              ln;
        int unsigned              pos;
        int unsigned              n;
        int                       best;
        res = '0;
        v   = it.value;
        ln  = it.lane;
        if (it.command == CMD_INSERT)
        begin
            if (ln >= LANES || lane_fill[ln] >= LANE_DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                n   = lane_fill[ln];
                pos = 0;
                // equal values stay ahead of the new one
                while (pos < n && !(v < lane_mem[ln][pos]))
                    pos++;
                for (int k = n; k > pos; k--)
                    lane_mem[ln][k] = lane_mem[ln][k - 1];
                lane_mem[ln][pos] = v;
                lane_fill[ln]     = n + 1;
                res.status        = ST_INSERTED;
            end
        end
        else
        begin
            best = -1;
            // ties go to the highest lane
            for (int i = 0; i < LANES; i++)
            begin
                if (lane_fill[i] != 0 && (best < 0 || !(lane_mem[best][0] < lane_mem[i][0])))
                    best = i;
            end
            if (best < 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                res.result_value = lane_mem[best][0];
                res.source_lane  = 3'(best);
                for (int k = 1; k < lane_fill[best]; k++)
                    lane_mem[best][k - 1] = lane_mem[best][k];
                lane_fill[best] = lane_fill[best] - 1;
                res.status      = ST_POPPED;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
                lane_fill[i] = 0;
            expected_results.delete();
            errors     = 0;
            pending    = 0;
            inserted   = 0;
            refused    = 0;
            popped     = 0;
            empty_pops = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected: value %0d lane %0d status %0d",
                             $time, rsp.item.result_value, rsp.item.source_lane,
                             rsp.item.status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.item.result_value !== want.result_value)
                    begin
                        errors++;
                        $display("%0t: result_value expected %0d, got %0d",
                                 $time, want.result_value, rsp.item.result_value);
                    end
                    if (rsp.item.source_lane !== want.source_lane)
                    begin
                        errors++;
                        $display("%0t: source_lane expected %0d, got %0d",
                                 $time, want.source_lane, rsp.item.source_lane);
                    end
                    if (rsp.item.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, rsp.item.status);
                    end
                    case (want.status)
                        ST_INSERTED: inserted++;
                        ST_FULL:     refused++;
                        ST_POPPED:   popped++;
                        default:     empty_pops++;
                    endcase
                end
            end
            if (req.valid && req.ready)
                expected_results.push_back(predict_merge_result(req.item));
            pending = expected_results.size();
        end
    end

endmodule

>>> verif/k_way_sorted_merge_tb.sv
`timescale 1ns / 1ps

module k_way_sorted_merge_tb;
    import kwm_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 64;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    bit          calm  = 1'b0;
    int unsigned cycle_count = 0;
    int          errors;
    int          pending;
    int          inserted;
    int          refused;
    int          popped;
    int          empty_pops;

    kwm_req_if req_ch ();
    kwm_rsp_if rsp_ch ();

    k_way_sorted_merge u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    kwm_merge_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .errors     (errors),
        .pending    (pending),
        .inserted   (inserted),
        .refused    (refused),
        .popped     (popped),
        .empty_pops (empty_pops)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("** k_way_sorted_merge: FAILED **");
            $finish;
        end
    end

    // narrow values so lanes see ties, some extremes, the rest full range
    function automatic logic signed [DATA_W-1:0] pick_value();
        int near;
        near = $urandom_range(0, 16);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return near - 8;
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return 0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic push_cmd(input command_t cmd, input logic [2:0] ln,
                            input logic signed [DATA_W-1:0] v);
        req_item_t it;
        it.command = cmd;
        it.lane    = ln;
        it.value   = v;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            req_ch.item  <= req_item_t'({$urandom, $urandom});
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.item  <= it;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    // result side: bursts of backpressure, none once calm
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clk);
        end
    end

    initial
    begin
        int count;
        int ins_pct;
        int lane_hi;
        req_ch.valid = 1'b0;
        req_ch.item  = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // pop with every lane empty
        push_cmd(CMD_POP, 3'd5, 32'sd1234);
        // fill lane 2 front-first in equal pairs; the first insert of each pair shifts the whole lane
        for (int i = 0; i < LANE_DEPTH; i++)
            push_cmd(CMD_INSERT, 3'd2, 2147483647 - (i / 2) * 1000);
        push_cmd(CMD_INSERT, 3'd2, 0);
        // equal heads in lanes 0 and 7, the higher lane leaves first
        push_cmd(CMD_INSERT, 3'd0, 32'sh8000_0000);
        push_cmd(CMD_INSERT, 3'd7, 32'sh8000_0000);
        push_cmd(CMD_POP, 3'd0, 32'sd0);
        push_cmd(CMD_POP, 3'd7, -1);
        push_cmd(CMD_POP, 3'd3, 32'sh7FFF_FFFF);

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:       begin count = 120; ins_pct = 75; lane_hi = 7; end
                1:       begin count = 100; ins_pct = 85; lane_hi = 1; end
                2:       begin count = 100; ins_pct = 25; lane_hi = 7; end
                3:       begin count = 80;  ins_pct = 60; lane_hi = 7; end
                default: begin count = 100; ins_pct = 50; lane_hi = 3; end
            endcase
            calm = (ph == 4);
            for (int n = 0; n < count; n++)
                push_cmd(($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_POP,
                         3'($urandom_range(0, lane_hi)), pick_value());
        end
        req_ch.valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d transactions over %0d cycles: %0d inserts stored, %0d refused",
                 inserted + refused + popped + empty_pops, cycle_count, inserted, refused);
        $display("%0d pops returned a head, %0d found every lane empty, %0d mismatches",
                 popped, empty_pops, errors);
        if (errors == 0 && pending == 0)
            $display("** k_way_sorted_merge: PASSED **");
        else
            $display("** k_way_sorted_merge: FAILED **");
        $finish;
    end

endmodule

>>> k_way_sorted_merge.f
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_req_if.sv
hw/rtl/kwm_rsp_if.sv
hw/rtl/kwm_dpath.sv
hw/rtl/kwm_ctrl.sv
hw/rtl/k_way_sorted_merge.sv
verif/kwm_merge_checker.sv
verif/k_way_sorted_merge_tb.sv
